[hdl/plm_pkg.sv]
package plm_pkg;

    localparam int MAX_CHANNELS_DEF = 8;

    localparam int SAMPLE_W  = 16;
    localparam int CHAN_W    = 3;
    localparam int LEVEL_W   = 12;
    localparam int LOG_W     = 20;   // 4-bit exponent, 16-bit fraction
    localparam int CFG_W     = 4;
    localparam int CFG_IDX_W = 1;

    // 20*log10(2)*16 in Q16: 1/16 dB per octave
    localparam logic [22:0] DB_PER_OCTAVE_Q16 = 23'd6313057;

    localparam logic signed [13:0] LEVEL_FLOOR = -14'sd1600;
    localparam logic signed [13:0] LEVEL_CEIL  = 14'sd2047;

    localparam logic [SAMPLE_W-1:0] AMP_16BIT = 16'd32767;
    localparam logic [SAMPLE_W-1:0] AMP_8BIT  = 16'd127;

    localparam logic [CFG_W-1:0] CHANNEL_COUNT_RST = 4'd2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CHANNEL_COUNT   = 1'b0,
        REG_SAMPLE_IS_16BIT = 1'b1
    } plm_reg_idx_t;

    // Same log2 as the hardware unit; used on constants at elaboration.
    function automatic logic [LOG_W-1:0] log2_q16(input logic [SAMPLE_W-1:0] x);
        logic [31:0] m;
        logic [3:0]  e;
        logic [15:0] frac;
        e    = 4'd0;
        frac = 16'd0;
        for (int i = 0; i < SAMPLE_W; i++) begin
            if (x[i]) e = 4'(i);
        end
        m = 32'(x) << (4'd15 - e);
        for (int i = 0; i < 16; i++) begin
            m    = (m * m) >> 15;
            frac = {frac[14:0], (m >= 32'd65536)};
            if (m >= 32'd65536) m = m >> 1;
        end
        return {e, frac};
    endfunction

    localparam logic [LOG_W-1:0] LOG_AMP_16BIT = log2_q16(AMP_16BIT);
    localparam logic [LOG_W-1:0] LOG_AMP_8BIT  = log2_q16(AMP_8BIT);

endpackage

[hdl/plm_peak_mem.sv]
module plm_peak_mem #(
    parameter int DEPTH = plm_pkg::MAX_CHANNELS_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          rd_en,
    input  logic [AW-1:0]                 rd_addr,
    output logic [plm_pkg::SAMPLE_W-1:0]  rd_data,
    input  logic                          wr_en,
    input  logic [AW-1:0]                 wr_addr,
    input  logic [plm_pkg::SAMPLE_W-1:0]  wr_data,
    input  logic                          clr
);
    import plm_pkg::*;

    logic [SAMPLE_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0]    valid_reg;
    logic [SAMPLE_W-1:0] rd_data_reg;
    logic                rd_valid_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) mem[wr_addr] <= wr_data;
        if (rd_en) rd_data_reg <= mem[rd_addr];
    end

    // entries that were never written since the last clear read as zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (rd_en) rd_valid_reg <= valid_reg[rd_addr];
            if (clr) begin
                valid_reg <= '0;
            end else if (wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

[hdl/plm_log2.sv]
module plm_log2 (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [plm_pkg::SAMPLE_W-1:0] x,
    output logic                         done,
    output logic [plm_pkg::LOG_W-1:0]    result
);
    import plm_pkg::*;

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic [15:0] m_reg, m_next;
    logic [3:0]  e_reg, e_next;
    logic [15:0] frac_reg, frac_next;

    logic [3:0]  enc;
    logic [15:0] norm;
    logic [31:0] sq;
    logic [16:0] sq_q15;

    // top set bit
    always_comb begin
        enc = 4'd0;
        for (int i = 0; i < SAMPLE_W; i++) begin
            if (x[i]) enc = 4'(i);
        end
    end

    assign norm   = x << (4'd15 - enc);
    assign sq     = 32'(m_reg) * 32'(m_reg);
    assign sq_q15 = sq[31:15];

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        m_next    = m_reg;
        e_next    = e_reg;
        frac_next = frac_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = 4'd0;
            m_next    = norm;
            e_next    = enc;
            frac_next = 16'd0;
        end else if (busy_reg) begin
            // square, take the integer bit as the next fraction bit, renormalize
            frac_next = {frac_reg[14:0], sq_q15[16]};
            m_next    = sq_q15[16] ? sq_q15[16:1] : sq_q15[15:0];
            cnt_next  = cnt_reg + 4'd1;
            if (cnt_reg == 4'd15) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 4'd0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_reg    <= m_next;
        e_reg    <= e_next;
        frac_reg <= frac_next;
    end

    assign done   = done_reg;
    assign result = {e_reg, frac_reg};

endmodule

[hdl/per_channel_peak_level_meter_unit.sv]
// Per-channel peak level meter. Interleaved samples enter on the s_ stream, the
// channel rotating from 0 up to the count minus one; each channel keeps the largest
// signed sample seen (8-bit mode: low byte, unsigned). On an item with s_tlast set
// the block first folds that sample in, then emits one item per channel, channel 0
// first, with the level 20*log10(peak/full_scale) in signed 1/16 dB (-1600 floor,
// silent set for a zero peak) and m_tlast on the highest channel; then it clears
// the peaks and the channel pointer. Peaks live in a one-port-read, registered
// memory: each sample is read, then compared and written back. In the level pass
// each channel's peak is read and checked; a silent channel goes straight to the
// output, others first through the bit-serial log2 unit, which squares once per
// fraction bit (16 iterations), and a multiply. No items are taken in the pass.
// Write configuration only while the block is idle.
module per_channel_peak_level_meter_unit #(
    parameter int MAX_CHANNELS = plm_pkg::MAX_CHANNELS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // configuration write port
    input  logic                          cfg_wr_en,
    input  logic [plm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [plm_pkg::CFG_W-1:0]     cfg_wdata,
    // sample stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [15:0]                   s_tdata,   // [15:0] sample
    input  logic                          s_tlast,   // last_sample
    // level stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [15:0]                   m_tdata,   // [2:0] channel, [14:3] level_db, [15] zero
    output logic [0:0]                    m_tuser,   // [0] silent
    output logic                          m_tlast    // last_level
);
    import plm_pkg::*;

    localparam int CH_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int N_W  = $clog2(MAX_CHANNELS + 1);

    typedef enum logic [6:0] {
        ST_IDLE    = 7'b0000001,
        ST_UPD     = 7'b0000010,
        ST_EM_RD   = 7'b0000100,
        ST_EM_PEAK = 7'b0001000,
        ST_EM_LOG  = 7'b0010000,
        ST_EM_MUL  = 7'b0100000,
        ST_EM_OUT  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    logic [CFG_W-1:0]    count_reg;
    logic                is16_reg;
    logic [CH_W-1:0]     ptr_reg, ptr_next;
    logic [CH_W-1:0]     ch_reg, ch_next;
    logic [CH_W-1:0]     k_reg, k_next;
    logic [SAMPLE_W-1:0] sample_reg, sample_next;
    logic                last_reg, last_next;
    logic                quiet_reg, quiet_next;
    logic                neg_reg, neg_next;
    logic [LOG_W-1:0]    mag_reg, mag_next;
    logic [43:0]         prod_reg, prod_next;

    logic                m_valid_reg, m_valid_next;
    logic [CHAN_W-1:0]   m_chan_reg, m_chan_next;
    logic [LEVEL_W-1:0]  m_level_reg, m_level_next;
    logic                m_silent_reg, m_silent_next;
    logic                m_last_reg, m_last_next;

    logic [N_W-1:0]      n_eff;
    logic [CH_W-1:0]     ch_eff;
    logic                s_acc;
    logic                out_free;
    logic                k_last;

    logic                mem_rd_en;
    logic [CH_W-1:0]     mem_rd_addr;
    logic [SAMPLE_W-1:0] mem_rd_data;
    logic                mem_wr_en;
    logic                mem_clr;

    logic                log_start;
    logic                log_done;
    logic [LOG_W-1:0]    log_result;

    logic [LOG_W-1:0]    amp_log;
    logic [LOG_W:0]      diff;
    logic [43:0]         rnd;
    logic [11:0]         r_mag;
    logic signed [13:0]  lv;
    logic signed [13:0]  lv_sat;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= CHANNEL_COUNT_RST;
            is16_reg  <= 1'b1;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_CHANNEL_COUNT:   count_reg <= cfg_wdata;
                REG_SAMPLE_IS_16BIT: is16_reg  <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // effective channel count: zero acts as one, clamp at MAX_CHANNELS
    always_comb begin
        if (count_reg == '0) begin
            n_eff = N_W'(1);
        end else if (32'(count_reg) > MAX_CHANNELS) begin
            n_eff = N_W'(MAX_CHANNELS);
        end else begin
            n_eff = N_W'(count_reg);
        end
    end

    // a pointer left beyond a lowered count restarts at channel 0
    assign ch_eff   = (N_W'(ptr_reg) >= n_eff) ? '0 : ptr_reg;
    assign s_tready = (state_reg == ST_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign k_last   = (N_W'(k_reg) + N_W'(1) == n_eff);

    assign amp_log = is16_reg ? LOG_AMP_16BIT : LOG_AMP_8BIT;
    assign diff    = {1'b0, log_result} - {1'b0, amp_log};

    // round half away from zero on the magnitude, then restore the sign
    assign rnd   = prod_reg + 44'h0_8000_0000;
    assign r_mag = rnd[43:32];
    assign lv    = neg_reg ? -$signed({2'b00, r_mag}) : $signed({2'b00, r_mag});

    always_comb begin
        if (quiet_reg || lv < LEVEL_FLOOR) begin
            lv_sat = LEVEL_FLOOR;
        end else if (lv > LEVEL_CEIL) begin
            lv_sat = LEVEL_CEIL;
        end else begin
            lv_sat = lv;
        end
    end

    always_comb begin
        state_next    = state_reg;
        ptr_next      = ptr_reg;
        ch_next       = ch_reg;
        k_next        = k_reg;
        sample_next   = sample_reg;
        last_next     = last_reg;
        quiet_next    = quiet_reg;
        neg_next      = neg_reg;
        mag_next      = mag_reg;
        prod_next     = prod_reg;
        m_valid_next  = m_valid_reg;
        m_chan_next   = m_chan_reg;
        m_level_next  = m_level_reg;
        m_silent_next = m_silent_reg;
        m_last_next   = m_last_reg;
        mem_rd_en     = 1'b0;
        mem_rd_addr   = k_reg;
        mem_wr_en     = 1'b0;
        mem_clr       = 1'b0;
        log_start     = 1'b0;

        if (m_valid_reg && m_tready) m_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    // hold the sample as a signed 16-bit value while the peak is read
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = ch_eff;
                    ch_next     = ch_eff;
                    sample_next = is16_reg ? s_tdata : {8'd0, s_tdata[7:0]};
                    last_next   = s_tlast;
                    state_next  = ST_UPD;
                end
            end
            ST_UPD: begin
                mem_wr_en = ($signed(sample_reg) > $signed(mem_rd_data));
                ptr_next  = (N_W'(ch_reg) + N_W'(1) == n_eff) ? '0
                                                             : CH_W'(ch_reg + CH_W'(1));
                if (last_reg) begin
                    k_next     = '0;
                    state_next = ST_EM_RD;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_EM_RD: begin
                mem_rd_en  = 1'b1;
                state_next = ST_EM_PEAK;
            end
            ST_EM_PEAK: begin
                // peaks never go negative; zero means silence
                quiet_next = ($signed(mem_rd_data) <= 0);
                neg_next   = 1'b1;
                prod_next  = '0;
                if ($signed(mem_rd_data) <= 0) begin
                    state_next = ST_EM_OUT;
                end else begin
                    log_start  = 1'b1;
                    state_next = ST_EM_LOG;
                end
            end
            ST_EM_LOG: begin
                if (log_done) begin
                    neg_next   = diff[LOG_W];
                    mag_next   = diff[LOG_W] ? LOG_W'(-diff) : diff[LOG_W-1:0];
                    state_next = ST_EM_MUL;
                end
            end
            ST_EM_MUL: begin
                prod_next  = 44'(mag_reg) * 44'(DB_PER_OCTAVE_Q16);
                state_next = ST_EM_OUT;
            end
            ST_EM_OUT: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_chan_next   = CHAN_W'(k_reg);
                    m_level_next  = LEVEL_W'(lv_sat);
                    m_silent_next = quiet_reg;
                    m_last_next   = k_last;
                    if (k_last) begin
                        // drop all peaks and restart the rotation
                        mem_clr    = 1'b1;
                        ptr_next   = '0;
                        state_next = ST_IDLE;
                    end else begin
                        k_next     = CH_W'(k_reg + CH_W'(1));
                        state_next = ST_EM_RD;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            ptr_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            ptr_reg     <= ptr_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        ch_reg       <= ch_next;
        k_reg        <= k_next;
        sample_reg   <= sample_next;
        last_reg     <= last_next;
        quiet_reg    <= quiet_next;
        neg_reg      <= neg_next;
        mag_reg      <= mag_next;
        prod_reg     <= prod_next;
        m_chan_reg   <= m_chan_next;
        m_level_reg  <= m_level_next;
        m_silent_reg <= m_silent_next;
        m_last_reg   <= m_last_next;
    end

    plm_peak_mem #(
        .DEPTH (MAX_CHANNELS),
        .AW    (CH_W)
    ) u_peak_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data),
        .wr_en   (mem_wr_en),
        .wr_addr (ch_reg),
        .wr_data (sample_reg),
        .clr     (mem_clr)
    );

    plm_log2 u_log2 (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (log_start),
        .x       (mem_rd_data),
        .done    (log_done),
        .result  (log_result)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, m_level_reg, m_chan_reg};
    assign m_tuser  = m_silent_reg;
    assign m_tlast  = m_last_reg;

endmodule

[tb/sv/per_channel_peak_level_meter_unit_tb.sv]
`timescale 1ns / 1ps

module per_channel_peak_level_meter_unit_tb;
    import plm_pkg::*;

    localparam int DIR_ROWS      = 38;
    localparam int RANDOM_ITEMS  = 380;
    localparam int SETTLE_CYCLES = 6;
    localparam int DRAIN_CYCLES  = 40;
    localparam int HOLD_AT       = 60;
    localparam int HOLD_CYCLES   = 300;
    localparam int CYCLE_LIMIT   = 400000;

    typedef enum logic {
        ROW_SAMPLE,
        ROW_WRITE
    } row_kind_t;

    // One directed step: either a sample item or a register write. Where
    // typed is set, every level item of that buffer must carry lvl and sil.
    typedef struct packed {
        row_kind_t          kind;
        plm_reg_idx_t       idx;
        logic [3:0]         val;
        logic [15:0]        smp;
        logic               lst;
        logic               typed;
        logic signed [11:0] lvl;
        logic               sil;
    } stim_row_t;

    typedef struct packed {
        logic [2:0]         chan;
        logic signed [11:0] level;
        logic               silent;
        logic               last;
    } level_rec_t;

    logic        aclk;
    logic        aresetn   = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [0:0]  cfg_index = '0;
    logic [3:0]  cfg_wdata = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata   = '0;     // [15:0] sample
    logic        s_tlast   = 1'b0;   // last_sample
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [15:0] m_tdata;            // [2:0] channel, [14:3] level_db, [15] zero
    logic [0:0]  m_tuser;            // [0] silent
    logic        m_tlast;            // last_level

    // Shadow of the meter: peaks, channel pointer and both registers.
    int          peak_mem [MAX_CHANNELS_DEF];
    int unsigned chan_ptr;
    logic [3:0]  cnt_reg;
    logic        mode16;

    level_rec_t  level_q [$];

    int   mismatches     = 0;
    int   items_sent     = 0;
    int   levels_checked = 0;
    int   regs_written   = 0;
    int   buffers_closed = 0;
    int   cycle_cnt      = 0;
    bit   tx_burst       = 1'b0;
    bit   rx_burst       = 1'b0;
    bit   held           = 1'b0;

    // Walk these first: reset state, full scale, negative-only channels,
    // out-of-range counts, 8-bit mode above full scale, a count lowered
    // mid-buffer, and a 16-bit peak metered after the switch to 8-bit.
    stim_row_t dir_table [DIR_ROWS] = '{
        '{ROW_SAMPLE, REG_CHANNEL_COUNT,   4'd0,  16'h0000, 1'b0, 1'b0, 12'sd0,     1'b0},
        '{ROW_SAMPLE, REG_CHANNEL_COUNT,   4'd0,  16'h0000, 1'b1, 1'b1, -12'sd1600, 1'b1},
        '{ROW_SAMPLE, REG_CHANNEL_COUNT,   4'd0,  16'h7FFF, 1'b0, 1'b0, 12'sd0,     1'b0},
        '{ROW_SAMPLE, REG_CHANNEL_COUNT,   4'd0,  16'h7FFF, 1'b1, 1'b1, 12'sd0,     1'b0},
        '{ROW_SAMPLE, REG_CHANNEL_COUNT,   4'd0,  16'h8000, 1'b0, 1'b0, 12'sd0,     1'b0},
        '{ROW_SAMPLE, REG_CHANNEL_COUNT,   4'd0,  16'h8000, 1'b1, 1'b1, -12'sd1600, 1'b1},
        '{ROW_SAMPLE, REG_CHANNEL_COUNT,   4'd0,  16'h0001, 1'b0, 1'b0, 12'sd0,     1'b0},
        '{ROW_SAMPLE, REG_CHANNEL_COUNT,   4'd0,  16'h4000, 1'b1, 1'b0, 12'sd0,     1'b0},
        '{ROW_WRITE,  REG_CHANNEL_COUNT,   4'd0,  16'h0000, 1'b0, 1'b0, 12'sd0,     1'b0},
        '{ROW_SAMPLE, REG_CHANNEL_COUNT,   4'd0,  16'hFFFF, 1'b1, 1'b1, -12'sd1600, 1'b1},
        '{ROW_SAMPLE, REG_CHANNEL_COUNT,   4'd0,  16'h3039, 1'b1, 1'b0, 12'sd0,     1'b0},
        '{ROW_WRITE,  REG_CHANNEL_COUNT,   4'd15, 16'h0000, 1'b0, 1'b0, 12'sd0,     1'b0},
        '{ROW_SAMPLE, REG_CHANNEL_COUNT,   4'd0,  16'h7FFF, 1'b0, 1'b0, 12'sd0,     1'b0},
        '{ROW_SAMPLE, REG_CHANNEL_COUNT,   4'd0,  16'h0001, 1'b0, 1'b0, 12'sd0,     1'b0},
        '{ROW_SAMPLE, REG_CHANNEL_COUNT,   4'd0,  16'h0000, 1'b0, 1'b0, 12'sd0,     1'b0},
        '{ROW_SAMPLE, REG_CHANNEL_COUNT,   4'd0,  16'h8000, 1'b0, 1'b0, 12'sd0,     1'b0},
        '{ROW_SAMPLE, REG_CHANNEL_COUNT,   4'd0,  16'h1234, 1'b0, 1'b0, 12'sd0,     1'b0},
        '{ROW_SAMPLE, REG_CHANNEL_COUNT,   4'd0,  16'h7FFE, 1'b0, 1'b0, 12'sd0,     1'b0},
        '{ROW_SAMPLE, REG_CHANNEL_COUNT,   4'd0,  16'h00FF, 1'b0, 1'b0, 12'sd0,     1'b0},
        '{ROW_SAMPLE, REG_CHANNEL_COUNT,   4'd0,  16'h5555, 1'b1, 1'b0, 12'sd0,     1'b0},
        '{ROW_WRITE,  REG_SAMPLE_IS_16BIT, 4'd0,  16'h0000, 1'b0, 1'b0, 12'sd0,     1'b0},
        '{ROW_WRITE,  REG_CHANNEL_COUNT,   4'd3,  16'h0000, 1'b0, 1'b0, 12'sd0,     1'b0},
        '{ROW_SAMPLE, REG_CHANNEL_COUNT,   4'd0,  16'h00FF, 1'b0, 1'b0, 12'sd0,     1'b0},
        '{ROW_SAMPLE, REG_CHANNEL_COUNT,   4'd0,  16'h807F, 1'b0, 1'b0, 12'sd0,     1'b0},
        '{ROW_SAMPLE, REG_CHANNEL_COUNT,   4'd0,  16'h1200, 1'b1, 1'b0, 12'sd0,     1'b0},
        '{ROW_WRITE,  REG_CHANNEL_COUNT,   4'd4,  16'h0000, 1'b0, 1'b0, 12'sd0,     1'b0},
        '{ROW_SAMPLE, REG_CHANNEL_COUNT,   4'd0,  16'h0040, 1'b0, 1'b0, 12'sd0,     1'b0},
        '{ROW_SAMPLE, REG_CHANNEL_COUNT,   4'd0,  16'h0010, 1'b0, 1'b0, 12'sd0,     1'b0},
        '{ROW_SAMPLE, REG_CHANNEL_COUNT,   4'd0,  16'h0020, 1'b0, 1'b0, 12'sd0,     1'b0},
        '{ROW_WRITE,  REG_CHANNEL_COUNT,   4'd2,  16'h0000, 1'b0, 1'b0, 12'sd0,     1'b0},
        '{ROW_SAMPLE, REG_CHANNEL_COUNT,   4'd0,  16'h0080, 1'b1, 1'b0, 12'sd0,     1'b0},
        '{ROW_WRITE,  REG_SAMPLE_IS_16BIT, 4'd1,  16'h0000, 1'b0, 1'b0, 12'sd0,     1'b0},
        '{ROW_WRITE,  REG_CHANNEL_COUNT,   4'd1,  16'h0000, 1'b0, 1'b0, 12'sd0,     1'b0},
        '{ROW_SAMPLE, REG_CHANNEL_COUNT,   4'd0,  16'h7FFF, 1'b0, 1'b0, 12'sd0,     1'b0},
        '{ROW_WRITE,  REG_SAMPLE_IS_16BIT, 4'd0,  16'h0000, 1'b0, 1'b0, 12'sd0,     1'b0},
        '{ROW_SAMPLE, REG_CHANNEL_COUNT,   4'd0,  16'h0000, 1'b1, 1'b0, 12'sd0,     1'b0},
        '{ROW_WRITE,  REG_CHANNEL_COUNT,   4'd2,  16'h0000, 1'b0, 1'b0, 12'sd0,     1'b0},
        '{ROW_WRITE,  REG_SAMPLE_IS_16BIT, 4'd1,  16'h0000, 1'b0, 1'b0, 12'sd0,     1'b0}
    };

    per_channel_peak_level_meter_unit #(
        .MAX_CHANNELS(MAX_CHANNELS_DEF)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // log2 in unsigned Q16: integer part from the top set bit, then one
    // fraction bit per squaring of the Q15 mantissa.
    function automatic int unsigned log2_fix(input logic [15:0] v);
        int unsigned      ex;
        int unsigned      frac;
        longint unsigned  mant;
        ex   = 0;
        frac = 0;
        if (v == 16'd0) begin
            return 0;
        end
        for (int b = 15; b >= 0; b--) begin
            if (v[b]) begin
                ex = b;
                break;
            end
        end
        mant = longint'(v) << (15 - ex);
        repeat (16) begin
            mant = (mant * mant) >> 15;
            frac = frac << 1;
            if (mant >= 64'd65536) begin
                mant = mant >> 1;
                frac = frac | 1;
            end
        end
        return (ex << 16) | frac;
    endfunction

    // Level of peak against full scale in 1/16 dB, rounded half away from
    // zero, then clamped to the floor and ceiling.
    function automatic logic signed [11:0] db_level(input logic [15:0] pk,
                                                    input logic [15:0] amp);
        longint d;
        longint mag;
        longint r;
        d   = longint'(log2_fix(pk)) - longint'(log2_fix(amp));
        mag = (d < 0 ? -d : d) * longint'(DB_PER_OCTAVE_Q16);
        r   = (mag + 64'sh8000_0000) >>> 32;
        if (d < 0) begin
            r = -r;
        end
        if (r < longint'(LEVEL_FLOOR)) begin
            r = longint'(LEVEL_FLOOR);
        end
        if (r > longint'(LEVEL_CEIL)) begin
            r = longint'(LEVEL_CEIL);
        end
        return r[11:0];
    endfunction

    // Count 0 behaves as 1, anything above the channel limit as the limit.
    function automatic int unsigned active_count();
        if (cnt_reg == 4'd0) begin
            return 1;
        end
        if (cnt_reg > MAX_CHANNELS_DEF) begin
            return MAX_CHANNELS_DEF;
        end
        return cnt_reg;
    endfunction

    // Fold one accepted sample into the shadow peaks; on a buffer end queue
    // one level item per channel, then clear peaks and pointer.
    function automatic void meter_sample(input logic [15:0] smp, input logic lst,
                                         input logic typed,
                                         input logic signed [11:0] t_lvl,
                                         input logic t_sil);
        int unsigned n;
        int unsigned ch;
        int          s;
        level_rec_t  rec;
        logic [15:0] amp;
        n  = active_count();
        ch = (chan_ptr >= n) ? 0 : chan_ptr;
        s  = mode16 ? int'($signed(smp)) : int'(smp[7:0]);
        if (s > peak_mem[ch]) begin
            peak_mem[ch] = s;
        end
        chan_ptr = (ch + 1) % n;
        if (!lst) begin
            return;
        end
        amp = mode16 ? AMP_16BIT : AMP_8BIT;
        for (int k = 0; k < n; k++) begin
            rec.chan   = 3'(k);
            rec.silent = (peak_mem[k] <= 0);
            rec.level  = rec.silent ? 12'(LEVEL_FLOOR) : db_level(16'(peak_mem[k]), amp);
            rec.last   = (k + 1 == n);
            // Table rows with a typed answer replace the computed level.
            if (typed) begin
                rec.level  = t_lvl;
                rec.silent = t_sil;
            end
            level_q.push_back(rec);
        end
        foreach (peak_mem[k]) begin
            peak_mem[k] = 0;
        end
        chan_ptr = 0;
        buffers_closed++;
    endfunction

    // Offer one sample item after a random gap and hold it until taken.
    task automatic push_sample(input logic [15:0] smp, input logic lst,
                               input logic typed, input logic signed [11:0] t_lvl,
                               input logic t_sil);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= smp;
        s_tlast  <= lst;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        meter_sample(smp, lst, typed, t_lvl, t_sil);
        items_sent++;
    endtask

    // Write a register only once the meter has gone quiet: drop valid, drain
    // all pending levels and let any sample still in flight settle.
    task automatic write_reg(input plm_reg_idx_t idx, input logic [3:0] val);
        s_tvalid <= 1'b0;
        while (level_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == REG_CHANNEL_COUNT) begin
            cnt_reg = val;
        end else begin
            mode16 = val[0];
        end
        regs_written++;
    endtask

    function automatic logic [15:0] pick_sample();
        case ($urandom_range(0, 4))
            0: begin
                return 16'($urandom_range(0, 16));
            end
            1: begin
                return 16'($urandom_range(32700, 32767));
            end
            2: begin
                return 16'h8000 | 16'($urandom);
            end
            3: begin
                return {8'($urandom), 8'($urandom_range(120, 255))};
            end
            default: begin
                return 16'($urandom);
            end
        endcase
    endfunction

    // Compare one taken level item with the oldest expectation.
    task automatic check_level();
        level_rec_t got;
        level_rec_t want;
        got.chan   = m_tdata[2:0];
        got.level  = m_tdata[14:3];
        got.silent = m_tuser[0];
        got.last   = m_tlast;
        if (level_q.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected level item, expected none, got ch %0d level %0d",
                     $time, got.chan, $signed(got.level));
            return;
        end
        want = level_q.pop_front();
        levels_checked++;
        if (got.chan !== want.chan) begin
            mismatches++;
            $display("%0t: channel mismatch, expected %0d, got %0d",
                     $time, want.chan, got.chan);
        end
        if (got.level !== want.level) begin
            mismatches++;
            $display("%0t: level_db mismatch on ch %0d, expected %0d, got %0d",
                     $time, want.chan, $signed(want.level), $signed(got.level));
        end
        if (got.silent !== want.silent) begin
            mismatches++;
            $display("%0t: silent mismatch on ch %0d, expected %0b, got %0b",
                     $time, want.chan, want.silent, got.silent);
        end
        if (got.last !== want.last) begin
            mismatches++;
            $display("%0t: last_level mismatch on ch %0d, expected %0b, got %0b",
                     $time, want.chan, want.last, got.last);
        end
    endtask

    // Hard stop in case the meter hangs.
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Level sink: take items with random stalls, and once hold ready low for
    // a long stretch so the meter backs up into its sample input.
    initial begin : level_sink
        int gap;
        wait (aresetn === 1'b1);
        forever begin
            gap = rx_burst ? 0 : $urandom_range(0, 5);
            if (!held && levels_checked >= HOLD_AT) begin
                held = 1'b1;
                gap  = HOLD_CYCLES;
            end
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            check_level();
            if ($urandom_range(0, 19) == 0) begin
                rx_burst = !rx_burst;
            end
        end
    end

    initial begin : sample_source
        int          rand_items;
        int          dir_items;
        int unsigned n;
        int          len;
        int          split;
        logic [3:0]  cnt_val;
        stim_row_t   row;

        // Shadow state matches the meter right after reset.
        foreach (peak_mem[k]) begin
            peak_mem[k] = 0;
        end
        chan_ptr = 0;
        cnt_reg  = CHANNEL_COUNT_RST;
        mode16   = 1'b1;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed table.
        foreach (dir_table[r]) begin
            row = dir_table[r];
            if (row.kind == ROW_WRITE) begin
                write_reg(row.idx, row.val);
            end else begin
                push_sample(row.smp, row.lst, row.typed, row.lvl, row.sil);
            end
        end
        dir_items = items_sent;

        // Random phases: new settings, then a few buffers, mostly whole
        // rounds of channels, sometimes ragged, now and then with the count
        // changed halfway through.
        rand_items = 0;
        while (rand_items < RANDOM_ITEMS) begin
            tx_burst = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 5))
                0: begin
                    cnt_val = 4'd0;
                end
                1: begin
                    cnt_val = 4'd1;
                end
                2: begin
                    cnt_val = 4'd8;
                end
                3: begin
                    cnt_val = 4'd15;
                end
                default: begin
                    cnt_val = 4'($urandom_range(1, 8));
                end
            endcase
            write_reg(REG_CHANNEL_COUNT, cnt_val);
            write_reg(REG_SAMPLE_IS_16BIT, 4'($urandom_range(0, 1)));
            repeat ($urandom_range(1, 4)) begin
                n = active_count();
                if ($urandom_range(0, 4) != 0) begin
                    len = n * $urandom_range(1, 3);
                end else begin
                    len = $urandom_range(1, 12);
                end
                split = ($urandom_range(0, 7) == 0) ? len / 2 : 0;
                for (int i = 0; i < len; i++) begin
                    if (split != 0 && i == split) begin
                        write_reg(REG_CHANNEL_COUNT, 4'($urandom_range(1, 8)));
                    end
                    push_sample(pick_sample(), i == len - 1, 1'b0, 12'sd0, 1'b0);
                    rand_items++;
                end
            end
        end

        // Drain: drop valid, wait for every level, then let the meter idle.
        s_tvalid <= 1'b0;
        while (level_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Run covered %0d sample items (%0d from the table) in %0d buffers,",
                 items_sent, dir_items, buffers_closed);
        $display("%0d level items checked, %0d register writes, %0d mismatches.",
                 levels_checked, regs_written, mismatches);
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
